[rtl/rtca_pkg.sv]
// rtca_pkg: shared types and constants for the two-alarm time-of-day clock
// no dependencies; imported by every module of the block
`default_nettype none

package rtca_pkg;

  localparam int SecMax  = 59;
  localparam int MinMax  = 59;
  localparam int HourMax = 23;
  localparam int AlarmResetVal = 9;

  // configuration register indexes
  localparam logic [2:0] CFG_A1_HOUR   = 3'd0;
  localparam logic [2:0] CFG_A1_MINUTE = 3'd1;
  localparam logic [2:0] CFG_A1_SECOND = 3'd2;
  localparam logic [2:0] CFG_A2_HOUR   = 3'd3;
  localparam logic [2:0] CFG_A2_MINUTE = 3'd4;

  // machine state codes
  localparam logic [1:0] MST_IDLE   = 2'd0;
  localparam logic [1:0] MST_ALARM1 = 2'd2;
  localparam logic [1:0] MST_ALARM2 = 2'd3;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } rtca_time_t;

  typedef struct packed {
    rtca_time_t a1;
    rtca_time_t a2;  // second field unused by alarm 2
  } rtca_alarm_cfg_t;

  typedef struct packed {
    logic [3:0] tick;
    rtca_time_t tod;
    logic       armed1;
    logic       armed2;
    logic [1:0] mstate;
  } rtca_state_t;

  typedef struct packed {
    logic       mode;
    rtca_time_t set_time;
  } rtca_item_t;

  typedef struct packed {
    rtca_time_t tod;
    logic       second_advanced;
    logic       alarm1_hit;
    logic       alarm2_hit;
    logic [1:0] unit_state;
  } rtca_result_t;

endpackage

`default_nettype wire

[rtl/rtca_cfg_regs.sv]
// rtca_cfg_regs: alarm setting registers behind the plain write port
// depends on rtca_pkg
`default_nettype none

module rtca_cfg_regs
  import rtca_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [5:0]      cfg_wdata,
  output rtca_alarm_cfg_t      alarm_cfg
);

  rtca_alarm_cfg_t alarm_r;
  rtca_alarm_cfg_t alarm_nxt;

  always_comb begin
    alarm_nxt = alarm_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_A1_HOUR:   alarm_nxt.a1.hour   = cfg_wdata[4:0];
        CFG_A1_MINUTE: alarm_nxt.a1.minute = cfg_wdata;
        CFG_A1_SECOND: alarm_nxt.a1.second = cfg_wdata;
        CFG_A2_HOUR:   alarm_nxt.a2.hour   = cfg_wdata[4:0];
        CFG_A2_MINUTE: alarm_nxt.a2.minute = cfg_wdata;
        default:       alarm_nxt = alarm_r;  // unknown index ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_r.a1.hour   <= 5'(AlarmResetVal);
      alarm_r.a1.minute <= 6'(AlarmResetVal);
      alarm_r.a1.second <= 6'(AlarmResetVal);
      alarm_r.a2.hour   <= 5'(AlarmResetVal);
      alarm_r.a2.minute <= 6'(AlarmResetVal);
      alarm_r.a2.second <= '0;
    end else begin
      alarm_r <= alarm_nxt;
    end
  end

  assign alarm_cfg = alarm_r;

endmodule

`default_nettype wire

[rtl/rtca_step.sv]
// rtca_step: next-state logic for one beat (prescaler, time load and rollover, alarms)
// depends on rtca_pkg; purely combinational
`default_nettype none

module rtca_step
  import rtca_pkg::*;
#(
  parameter int TICK_LIMIT = 10
) (
  input  wire rtca_state_t     state_cur,
  input  wire rtca_item_t      item,
  input  wire rtca_alarm_cfg_t alarm_cfg,
  output rtca_state_t          state_nxt,
  output rtca_result_t         res_nxt
);

  logic [6:0] sec_inc;
  logic [6:0] min_inc;
  logic [5:0] hour_inc;
  rtca_time_t adv_time;
  logic       hit1;
  logic       hit2;

  // one-second advance; out-of-range fields wrap here as well
  always_comb begin
    sec_inc  = {1'b0, state_cur.tod.second} + 7'd1;
    min_inc  = {1'b0, state_cur.tod.minute};
    hour_inc = {1'b0, state_cur.tod.hour};
    if (sec_inc > 7'(SecMax)) begin
      min_inc = min_inc + 7'd1;
      sec_inc = '0;
    end
    if (min_inc > 7'(MinMax)) begin
      hour_inc = hour_inc + 6'd1;
      min_inc  = '0;
    end
    if (hour_inc > 6'(HourMax)) begin
      hour_inc = '0;
    end
    adv_time.second = sec_inc[5:0];
    adv_time.minute = min_inc[5:0];
    adv_time.hour   = hour_inc[4:0];
  end

  assign hit1 = state_cur.armed1 &&
                adv_time.hour   == alarm_cfg.a1.hour &&
                adv_time.minute == alarm_cfg.a1.minute &&
                adv_time.second == alarm_cfg.a1.second;
  assign hit2 = state_cur.armed2 &&
                adv_time.hour   == alarm_cfg.a2.hour &&
                adv_time.minute == alarm_cfg.a2.minute;

  always_comb begin
    state_nxt               = state_cur;
    res_nxt.second_advanced = 1'b0;
    res_nxt.alarm1_hit      = 1'b0;
    res_nxt.alarm2_hit      = 1'b0;
    if (item.mode) begin
      state_nxt.tod = item.set_time;
    end else if (state_cur.tick > 4'(TICK_LIMIT)) begin
      state_nxt.tick          = '0;
      state_nxt.tod           = adv_time;
      res_nxt.second_advanced = 1'b1;
      if (hit1) begin
        state_nxt.armed1   = 1'b0;
        state_nxt.mstate   = MST_ALARM1;
        res_nxt.alarm1_hit = 1'b1;
      end
      // alarm 2 wins when both match
      if (hit2) begin
        state_nxt.armed2   = 1'b0;
        state_nxt.mstate   = MST_ALARM2;
        res_nxt.alarm2_hit = 1'b1;
      end
    end else begin
      state_nxt.tick = state_cur.tick + 4'd1;
    end
    res_nxt.tod        = state_nxt.tod;
    res_nxt.unit_state = state_nxt.mstate;
  end

endmodule

`default_nettype wire

[rtl/rtc_clock_with_two_alarms_core.sv]
// path: an accepted beat waits in the input register, then enters the result register
// (out_*) once that is free; throughput: one beat per cycle while out_ready stays high;
// the step logic sits between the two registers, and the clock state updates once per beat
// reset: rst_n synchronous active low; clears the pipeline valids, the clock, the prescaler
// and machine state, arms both alarms and sets alarm times to 9 (alarm 2 second field to 0)
`default_nettype none

module rtc_clock_with_two_alarms_core
  import rtca_pkg::*;
#(
  parameter int TICK_LIMIT = 10
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_mode,
  input  wire logic [4:0] in_set_hour,
  input  wire logic [5:0] in_set_minute,
  input  wire logic [5:0] in_set_second,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [4:0]      out_cur_hour,
  output logic [5:0]      out_cur_minute,
  output logic [5:0]      out_cur_second,
  output logic            out_second_advanced,
  output logic            out_alarm1_hit,
  output logic            out_alarm2_hit,
  output logic [1:0]      out_unit_state,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [5:0] cfg_wdata
);

  rtca_alarm_cfg_t alarm_cfg;
  rtca_state_t     state_r;
  rtca_state_t     state_nxt;
  rtca_item_t      item_r;
  rtca_result_t    res_nxt;
  rtca_result_t    res_r;
  logic            s1_valid_r;
  logic            out_valid_r;
  logic            out_take;
  logic            s1_go;

  rtca_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .alarm_cfg (alarm_cfg)
  );

  rtca_step #(
    .TICK_LIMIT (TICK_LIMIT)
  ) u_step (
    .state_cur (state_r),
    .item      (item_r),
    .alarm_cfg (alarm_cfg),
    .state_nxt (state_nxt),
    .res_nxt   (res_nxt)
  );

  // result register frees up when empty or when its beat is taken
  assign out_take = !out_valid_r || out_ready;
  assign s1_go    = s1_valid_r && out_take;
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      state_r.tick   <= '0;
      state_r.tod    <= '0;
      state_r.armed1 <= 1'b1;
      state_r.armed2 <= 1'b1;
      state_r.mstate <= MST_IDLE;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_take) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_go) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.mode            <= in_mode;
      item_r.set_time.hour   <= in_set_hour;
      item_r.set_time.minute <= in_set_minute;
      item_r.set_time.second <= in_set_second;
    end
    if (s1_go) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cur_hour        = res_r.tod.hour;
  assign out_cur_minute      = res_r.tod.minute;
  assign out_cur_second      = res_r.tod.second;
  assign out_second_advanced = res_r.second_advanced;
  assign out_alarm1_hit      = res_r.alarm1_hit;
  assign out_alarm2_hit      = res_r.alarm2_hit;
  assign out_unit_state      = res_r.unit_state;

endmodule

`default_nettype wire

[rtl/rtca_checker.sv]
// rtca_checker: port-level assertions for the two-alarm clock, bound to the top level
// depends on rtca_pkg and rtc_clock_with_two_alarms_core
`default_nettype none

module rtca_checker
  import rtca_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [4:0] out_cur_hour,
  input wire logic [5:0] out_cur_minute,
  input wire logic [5:0] out_cur_second,
  input wire logic       out_second_advanced,
  input wire logic       out_alarm1_hit,
  input wire logic       out_alarm2_hit,
  input wire logic [1:0] out_unit_state
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cur_hour) &&
    $stable(out_cur_minute) && $stable(out_cur_second) && $stable(out_unit_state))
    else $error("result beat changed while stalled");

  // alarms only fire on a second advance
  a_hit_needs_adv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_alarm1_hit || out_alarm2_hit) |-> out_second_advanced)
    else $error("alarm hit without second advance");

  a_alarm2_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alarm2_hit |-> out_unit_state == MST_ALARM2)
    else $error("alarm 2 hit without alarm 2 state");

  a_alarm1_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alarm1_hit && !out_alarm2_hit |-> out_unit_state == MST_ALARM1)
    else $error("alarm 1 hit without alarm 1 state");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind rtc_clock_with_two_alarms_core rtca_checker u_rtca_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_cur_hour        (out_cur_hour),
  .out_cur_minute      (out_cur_minute),
  .out_cur_second      (out_cur_second),
  .out_second_advanced (out_second_advanced),
  .out_alarm1_hit      (out_alarm1_hit),
  .out_alarm2_hit      (out_alarm2_hit),
  .out_unit_state      (out_unit_state)
);

`default_nettype wire

[tb/rtc_clock_with_two_alarms_core_tb.sv]
// rtc_clock_with_two_alarms_core_tb: self-checking bench for the two-alarm time-of-day clock
// keeps its own copy of the clock state and checks every result beat in order
// depends on rtca_pkg and rtc_clock_with_two_alarms_core
`timescale 1ns / 100ps

module rtc_clock_with_two_alarms_core_tb;
  import rtca_pkg::*;

  localparam int TICK_LIMIT = 10;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES = 5;
  localparam int PHASE_BEATS = 250;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_SET  = 1'b1;
  // first index past the register file, writes there must do nothing
  localparam logic [2:0] CFG_SPARE = 3'd5;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_mode = MODE_TICK;
  logic [4:0] in_set_hour = '0;
  logic [5:0] in_set_minute = '0;
  logic [5:0] in_set_second = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [4:0] out_cur_hour;
  logic [5:0] out_cur_minute;
  logic [5:0] out_cur_second;
  logic       out_second_advanced;
  logic       out_alarm1_hit;
  logic       out_alarm2_hit;
  logic [1:0] out_unit_state;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [5:0] cfg_wdata = '0;

  rtc_clock_with_two_alarms_core #(.TICK_LIMIT(TICK_LIMIT)) uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rtca_state_t     tod_model;
  rtca_alarm_cfg_t alarm_times;
  rtca_item_t      pending_beats[$];
  rtca_result_t    expected_readings[$];

  int send_gap = 0;
  bit send_burst = 1'b0;
  int rcv_stall = 0;
  bit rcv_burst = 1'b0;
  int idle_cycles = 0;
  int mismatches = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int advances = 0;
  int loads = 0;
  int alarm1_fired = 0;
  int alarm2_fired = 0;

  // mostly short gaps, now and then a long one
  function automatic int draw_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic step_clock(input rtca_item_t it, output rtca_result_t r);
    logic [6:0] s;
    logic [6:0] m;
    logic [5:0] h;
    r = '0;
    if (it.mode == MODE_SET) begin
      tod_model.tod = it.set_time;
    end else if (tod_model.tick > TICK_LIMIT) begin
      tod_model.tick = '0;
      r.second_advanced = 1'b1;
      s = {1'b0, tod_model.tod.second} + 7'd1;
      m = {1'b0, tod_model.tod.minute};
      h = {1'b0, tod_model.tod.hour};
      // minute and hour clamp even without a carry in
      if (s > SecMax) begin
        m = m + 7'd1;
        s = '0;
      end
      if (m > MinMax) begin
        h = h + 6'd1;
        m = '0;
      end
      if (h > HourMax) h = '0;
      tod_model.tod.second = s[5:0];
      tod_model.tod.minute = m[5:0];
      tod_model.tod.hour = h[4:0];
      if (tod_model.armed1 && tod_model.tod == alarm_times.a1) begin
        tod_model.armed1 = 1'b0;
        tod_model.mstate = MST_ALARM1;
        r.alarm1_hit = 1'b1;
      end
      if (tod_model.armed2 && tod_model.tod.hour == alarm_times.a2.hour &&
          tod_model.tod.minute == alarm_times.a2.minute) begin
        tod_model.armed2 = 1'b0;
        tod_model.mstate = MST_ALARM2;
        r.alarm2_hit = 1'b1;
      end
    end else begin
      tod_model.tick = tod_model.tick + 4'd1;
    end
    r.tod = tod_model.tod;
    r.unit_state = tod_model.mstate;
  endtask

  always @(posedge clk) begin : driver
    rtca_item_t cur;
    rtca_item_t nxt;
    rtca_result_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        cur = {in_mode, in_set_hour, in_set_minute, in_set_second};
        step_clock(cur, r);
        expected_readings.push_back(r);
        beats_sent++;
        if (cur.mode == MODE_SET) loads++;
        if (r.second_advanced) advances++;
        if (r.alarm1_hit) alarm1_fired++;
        if (r.alarm2_hit) alarm2_fired++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          nxt = pending_beats.pop_front();
          in_valid <= 1'b1;
          in_mode <= nxt.mode;
          in_set_hour <= nxt.set_time.hour;
          in_set_minute <= nxt.set_time.minute;
          in_set_second <= nxt.set_time.second;
          send_gap = draw_gap(send_burst);
          if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    rtca_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        check_field("cur_hour", want.tod.hour, out_cur_hour);
        check_field("cur_minute", want.tod.minute, out_cur_minute);
        check_field("cur_second", want.tod.second, out_cur_second);
        check_field("second_advanced", want.second_advanced, out_second_advanced);
        check_field("alarm1_hit", want.alarm1_hit, out_alarm1_hit);
        check_field("alarm2_hit", want.alarm2_hit, out_alarm2_hit);
        check_field("unit_state", want.unit_state, out_unit_state);
        beats_checked++;
      end
    end
    if (rcv_stall > 0) begin
      rcv_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) rcv_stall = draw_gap(rcv_burst);
    end
    if ($urandom_range(0, 63) == 0) rcv_burst = !rcv_burst;
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: %0d cycles without a beat", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [5:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_A1_HOUR:   alarm_times.a1.hour = val[4:0];
      CFG_A1_MINUTE: alarm_times.a1.minute = val;
      CFG_A1_SECOND: alarm_times.a1.second = val;
      CFG_A2_HOUR:   alarm_times.a2.hour = val[4:0];
      CFG_A2_MINUTE: alarm_times.a2.minute = val;
      default: ;
    endcase
  endtask

  // all five alarm registers plus one write past the end of the file
  task automatic set_alarms(input logic [5:0] h1, m1, s1, h2, m2);
    write_reg(CFG_A1_HOUR, h1);
    write_reg(CFG_A1_MINUTE, m1);
    write_reg(CFG_A1_SECOND, s1);
    write_reg(CFG_A2_HOUR, h2);
    write_reg(CFG_A2_MINUTE, m2);
    write_reg(CFG_SPARE + 3'($urandom_range(0, 2)), 6'($urandom_range(0, 63)));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_tick();
    rtca_item_t it;
    it.mode = MODE_TICK;
    it.set_time.hour = 5'($urandom_range(0, 31));
    it.set_time.minute = 6'($urandom_range(0, 63));
    it.set_time.second = 6'($urandom_range(0, 63));
    pending_beats.push_back(it);
  endtask

  task automatic push_set(input int h, m, s);
    rtca_item_t it;
    it.mode = MODE_SET;
    it.set_time.hour = 5'(h);
    it.set_time.minute = 6'(m);
    it.set_time.second = 6'(s);
    pending_beats.push_back(it);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_readings.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  initial begin : stimulus
    int r;
    tod_model = '0;
    tod_model.armed1 = 1'b1;
    tod_model.armed2 = 1'b1;
    tod_model.mstate = MST_IDLE;
    alarm_times.a1 = '{hour: AlarmResetVal, minute: AlarmResetVal, second: AlarmResetVal};
    alarm_times.a2 = '{hour: AlarmResetVal, minute: AlarmResetVal, second: AlarmResetVal};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // both alarms land on the last second of the day
    set_alarms(HourMax, MinMax, SecMax, HourMax, MinMax);
    repeat (TICK_LIMIT + 1) push_tick();
    push_set(HourMax, MinMax, SecMax - 1);
    push_tick();
    repeat (TICK_LIMIT + 1) push_tick();
    // out-of-range load, every field clamps on the next advance
    push_set(31, 63, 63);
    push_tick();
    push_set(0, 0, 0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) set_alarms('0, '0, '0, '0, '0);
      else if (p == 1) set_alarms('1, '1, '1, '1, '1);
      else set_alarms(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                      6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                      6'($urandom_range(0, 63)));
      for (int i = 0; i < PHASE_BEATS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 82) push_tick();
        else if (r < 91)
          push_set($urandom_range(0, 1) ? HourMax : $urandom_range(0, HourMax),
                   $urandom_range(MinMax - 2, MinMax), $urandom_range(SecMax - 9, SecMax));
        else if (r < 96)
          push_set($urandom_range(0, HourMax), $urandom_range(0, MinMax),
                   $urandom_range(0, SecMax));
        else push_set($urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
      end
      drain();
    end

    $display("sent %0d beats (%0d time loads), checked %0d results", beats_sent, loads,
             beats_checked);
    $display("seconds advanced %0d times, alarm 1 fired %0d, alarm 2 fired %0d", advances,
             alarm1_fired, alarm2_fired);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/rtca_pkg.sv
rtl/rtca_cfg_regs.sv
rtl/rtca_step.sv
rtl/rtc_clock_with_two_alarms_core.sv
rtl/rtca_checker.sv
tb/rtc_clock_with_two_alarms_core_tb.sv
